@@ hw/rtl/hdri_pkg.sv @@
package hdri_pkg;

   // Field and datapath widths
   localparam int ANGLE_W = 16;
   localparam int SPEED_W = 16;
   localparam int STEP_W  = 16;
   localparam int POS_W   = 32;
   localparam int SUM_W   = 18;   // heading plus steering increment, signed
   localparam int REM_W   = 14;   // remainder within one quadrant
   localparam int Z_W     = 30;   // CORDIC angle, 2^-21 degree units
   localparam int XY_W    = 34;   // CORDIC vector, Q2.30 with headroom
   localparam int TRIG_W  = 35;   // signed sine/cosine after quadrant mapping
   localparam int LO_W    = 17;   // low slice of a trig value for the multiplier
   localparam int OP_W    = 18;   // multiplier operand taken from a trig value
   localparam int VDT_W   = 32;   // speed * time_step
   localparam int PROD_W  = 50;
   localparam int ACC_W   = 68;
   localparam int DELTA_W = 34;
   localparam int ATAN_W  = 27;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [SUM_W-1:0] FULL_TURN = 18'sd46080;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN   = 16'd11520;
   localparam logic [ANGLE_W-1:0] HALF_TURN      = 16'd23040;
   localparam logic [ANGLE_W-1:0] THREE_QUARTERS = 16'd34560;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [STEP_W-1:0] TIME_STEP_RESET  = 16'd4096;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 68'sh0_0000_0002_0000_0000;
   localparam int SHIFT_OUT = 34;
   localparam int HI_SHIFT  = 17;
   localparam logic signed [POS_W+2:0] POS_MAX = 35'sd2147483647;
   localparam logic signed [POS_W+2:0] POS_MIN = -35'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUAD,
      ST_ROT,
      ST_MAP,
      ST_MUL_XL,
      ST_MUL_XH,
      ST_MUL_YL,
      ST_MUL_YH,
      ST_ADD_Y,
      ST_UPD_Y,
      ST_OUT
   } hdri_state_type;

   typedef enum logic [1:0] {
      MUL_SIN_LO,
      MUL_SIN_HI,
      MUL_COS_LO,
      MUL_COS_HI
   } hdri_mul_sel_type;

   typedef struct packed {
      logic             accept;
      logic             quad_load;
      logic             rot_step;
      logic             map_load;
      logic             mul_en;
      hdri_mul_sel_type mul_sel;
      logic             acc_load;
      logic             acc_add;
      logic             pos_x_upd;
      logic             pos_y_upd;
      logic             out_load;
   } hdri_cmd_type;

   typedef struct packed {
      logic rot_last;
   } hdri_status_type;

   // atan(2^-i) in 2^-21 degree units, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_deg21(input logic [4:0] idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         5'd0:    val = 27'd94371840;
         5'd1:    val = 27'd55710950;
         5'd2:    val = 27'd29436136;
         5'd3:    val = 27'd14942242;
         5'd4:    val = 27'd7500117;
         5'd5:    val = 27'd3753715;
         5'd6:    val = 27'd1877315;
         5'd7:    val = 27'd938715;
         5'd8:    val = 27'd469365;
         5'd9:    val = 27'd234683;
         5'd10:   val = 27'd117342;
         5'd11:   val = 27'd58671;
         5'd12:   val = 27'd29335;
         5'd13:   val = 27'd14668;
         5'd14:   val = 27'd7334;
         5'd15:   val = 27'd3667;
         5'd16:   val = 27'd1833;
         5'd17:   val = 27'd917;
         5'd18:   val = 27'd458;
         5'd19:   val = 27'd229;
         5'd20:   val = 27'd115;
         5'd21:   val = 27'd57;
         5'd22:   val = 27'd29;
         5'd23:   val = 27'd14;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+2:0] v);
      logic signed [POS_W-1:0] res;
      if (v > POS_MAX) begin
         res = POS_MAX[POS_W-1:0];
      end else if (v < POS_MIN) begin
         res = POS_MIN[POS_W-1:0];
      end else begin
         res = v[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/hdri_if.sv @@
interface hdri_req_if;
   import hdri_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [ANGLE_W-1:0]  steer_delta;
   logic signed [SPEED_W-1:0]  speed;

   modport source (output valid, output steer_delta, output speed, input ready);
   modport sink   (input valid, input steer_delta, input speed, output ready);
endinterface

interface hdri_rsp_if;
   import hdri_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [POS_W-1:0]   new_x;
   logic signed [POS_W-1:0]   new_y;
   logic [ANGLE_W-1:0]        new_heading;

   modport source (output valid, output new_x, output new_y, output new_heading,
                   input ready);
   modport sink   (input valid, input new_x, input new_y, input new_heading,
                   output ready);
endinterface

@@ hw/rtl/hdri_ctrl.sv @@
module hdri_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hdri_pkg::hdri_cmd_type    cmd,
   input  hdri_pkg::hdri_status_type status
);
   import hdri_pkg::*;

   hdri_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_sel = MUL_SIN_LO;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_QUAD;
            end
         end
         ST_QUAD: begin
            cmd.quad_load = 1'b1;
            state_in      = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot_step = 1'b1;
            if (status.rot_last) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map_load = 1'b1;
            state_in     = ST_MUL_XL;
         end
         ST_MUL_XL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SIN_LO;
            state_in    = ST_MUL_XH;
         end
         ST_MUL_XH: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_SIN_HI;
            cmd.acc_load = 1'b1;
            state_in     = ST_MUL_YL;
         end
         ST_MUL_YL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_COS_LO;
            cmd.acc_add = 1'b1;
            state_in    = ST_MUL_YH;
         end
         ST_MUL_YH: begin
            // x sum is complete in the accumulator; start y in the same cycle
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_COS_HI;
            cmd.acc_load  = 1'b1;
            cmd.pos_x_upd = 1'b1;
            state_in      = ST_ADD_Y;
         end
         ST_ADD_Y: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_UPD_Y;
         end
         ST_UPD_Y: begin
            cmd.pos_y_upd = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            // hold until the previous transaction has left the output register
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_rot_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT && status.rot_last) |=> state_ff == ST_MAP)
      else $error("rotation did not hand over to quadrant mapping");

endmodule

@@ hw/rtl/hdri_datapath.sv @@
module hdri_datapath #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hdri_pkg::hdri_cmd_type              cmd,
   output hdri_pkg::hdri_status_type           status,
   input  logic signed [hdri_pkg::ANGLE_W-1:0] steer_delta,
   input  logic signed [hdri_pkg::SPEED_W-1:0] speed,
   input  logic                                csr_wr_en,
   input  logic [hdri_pkg::STEP_W-1:0]         csr_wr_data,
   output logic signed [hdri_pkg::POS_W-1:0]   new_x,
   output logic signed [hdri_pkg::POS_W-1:0]   new_y,
   output logic [hdri_pkg::ANGLE_W-1:0]        new_heading
);
   import hdri_pkg::*;

   localparam int ITER_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   logic [STEP_W-1:0]         time_step_ff, time_step_in;
   logic [ANGLE_W-1:0]        heading_ff, heading_in;
   logic signed [POS_W-1:0]   pos_x_ff, pos_x_in;
   logic signed [POS_W-1:0]   pos_y_ff, pos_y_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic [1:0]                quad_ff, quad_in;
   logic signed [Z_W-1:0]     z_ff, z_in;
   logic signed [XY_W-1:0]    cx_ff, cx_in;
   logic signed [XY_W-1:0]    cy_ff, cy_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [VDT_W-1:0]   vdt_ff, vdt_in;
   logic signed [TRIG_W-1:0]  sin_ff, sin_in;
   logic signed [TRIG_W-1:0]  cos_ff, cos_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [POS_W-1:0]   out_x_ff, out_x_in;
   logic signed [POS_W-1:0]   out_y_ff, out_y_in;
   logic [ANGLE_W-1:0]        out_heading_ff, out_heading_in;

   logic signed [SUM_W-1:0]   head_sum;
   logic signed [SUM_W-1:0]   head_wrap;
   logic [ANGLE_W-1:0]        quad_base;
   logic [REM_W-1:0]          rem;
   logic signed [XY_W-1:0]    dx;
   logic signed [XY_W-1:0]    dy;
   logic signed [Z_W-1:0]     atan_step;
   logic signed [TRIG_W-1:0]  c_ext;
   logic signed [TRIG_W-1:0]  s_ext;
   logic signed [OP_W-1:0]    mul_op;
   logic signed [DELTA_W-1:0] delta;
   logic signed [POS_W+2:0]   pos_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         heading_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         iter_ff      <= '0;
      end else begin
         time_step_ff <= time_step_in;
         heading_ff   <= heading_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         iter_ff      <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      speed_ff       <= speed_in;
      quad_ff        <= quad_in;
      z_ff           <= z_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      vdt_ff         <= vdt_in;
      sin_ff         <= sin_in;
      cos_ff         <= cos_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_heading_ff <= out_heading_in;
   end

   // heading wrap, one correction either way covers the whole increment range
   always_comb begin
      head_sum = signed'({2'b00, heading_ff}) + SUM_W'(steer_delta);
      if (head_sum < 0) begin
         head_wrap = head_sum + FULL_TURN;
      end else if (head_sum >= FULL_TURN) begin
         head_wrap = head_sum - FULL_TURN;
      end else begin
         head_wrap = head_sum;
      end
   end

   always_comb begin
      if (heading_ff < QUARTER_TURN) begin
         quad_in   = 2'd0;
         quad_base = '0;
      end else if (heading_ff < HALF_TURN) begin
         quad_in   = 2'd1;
         quad_base = QUARTER_TURN;
      end else if (heading_ff < THREE_QUARTERS) begin
         quad_in   = 2'd2;
         quad_base = HALF_TURN;
      end else begin
         quad_in   = 2'd3;
         quad_base = THREE_QUARTERS;
      end
      rem = REM_W'(heading_ff - quad_base);
   end

   assign dx        = cy_ff >>> iter_ff;
   assign dy        = cx_ff >>> iter_ff;
   assign atan_step = signed'(Z_W'(atan_deg21(5'(iter_ff))));
   assign c_ext     = TRIG_W'(cx_ff);
   assign s_ext     = TRIG_W'(cy_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_SIN_LO: mul_op = signed'({1'b0, sin_ff[LO_W-1:0]});
         MUL_SIN_HI: mul_op = sin_ff[TRIG_W-1:LO_W];
         MUL_COS_LO: mul_op = signed'({1'b0, cos_ff[LO_W-1:0]});
         MUL_COS_HI: mul_op = cos_ff[TRIG_W-1:LO_W];
         default:    mul_op = '0;
      endcase
   end

   assign delta   = DELTA_W'(acc_ff >>> SHIFT_OUT);
   assign pos_sum = (POS_W+3)'(cmd.pos_x_upd ? pos_x_ff : pos_y_ff) + (POS_W+3)'(delta);

   always_comb begin
      time_step_in   = time_step_ff;
      heading_in     = heading_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      speed_in       = speed_ff;
      z_in           = z_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      iter_in        = iter_ff;
      vdt_in         = vdt_ff;
      sin_in         = sin_ff;
      cos_in         = cos_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_heading_in = out_heading_ff;

      if (csr_wr_en) begin
         time_step_in = csr_wr_data;
      end

      if (cmd.accept) begin
         heading_in = head_wrap[ANGLE_W-1:0];
         speed_in   = speed;
      end

      if (cmd.quad_load) begin
         z_in    = signed'({2'b00, rem, 14'b0});
         cx_in   = CORDIC_GAIN;
         cy_in   = '0;
         iter_in = '0;
         vdt_in  = VDT_W'(speed_ff) * VDT_W'(signed'({1'b0, time_step_ff}));
      end

      if (cmd.rot_step) begin
         iter_in = iter_ff + 1'b1;
         if (z_ff >= 0) begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            z_in  = z_ff - atan_step;
         end else begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            z_in  = z_ff + atan_step;
         end
      end

      if (cmd.map_load) begin
         case (quad_ff)
            2'd0: begin
               sin_in = s_ext;
               cos_in = c_ext;
            end
            2'd1: begin
               sin_in = c_ext;
               cos_in = -s_ext;
            end
            2'd2: begin
               sin_in = -s_ext;
               cos_in = -c_ext;
            end
            default: begin
               sin_in = -c_ext;
               cos_in = s_ext;
            end
         endcase
      end

      if (cmd.mul_en) begin
         prod_in = PROD_W'(vdt_ff) * PROD_W'(mul_op);
      end

      if (cmd.acc_load) begin
         acc_in = ACC_W'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + (ACC_W'(prod_ff) <<< HI_SHIFT) + ROUND_HALF;
      end

      if (cmd.pos_x_upd) begin
         pos_x_in = sat_pos(pos_sum);
      end
      if (cmd.pos_y_upd) begin
         pos_y_in = sat_pos(pos_sum);
      end

      if (cmd.out_load) begin
         out_x_in       = pos_x_ff;
         out_y_in       = pos_y_ff;
         out_heading_in = heading_ff;
      end
   end

   assign status.rot_last = (iter_ff == ITER_LAST);
   assign new_x           = out_x_ff;
   assign new_y           = out_y_ff;
   assign new_heading     = out_heading_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      heading_ff < FULL_TURN[ANGLE_W-1:0])
      else $error("heading outside one turn");

   a_angle_in_quadrant: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.quad_load) |-> (z_ff >= 0 && z_ff < signed'(Z_W'(QUARTER_TURN) <<< 14)))
      else $error("CORDIC angle outside one quadrant");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (new_x == pos_x_ff && new_y == pos_y_ff
                        && new_heading == heading_ff))
      else $error("result register does not match integrator state");

endmodule

@@ hw/rtl/heading_dead_reckoning_integrator.sv @@
// Dead-reckoning integrator: each request transaction adds steer_delta to the stored
// heading (1/128 degree, wrapped to one turn), takes sine and cosine of the new heading
// from an iterative CORDIC, and adds speed*time_step*sin/cos to the saturating Q16.16
// x/y position. One response transaction with the new x, y and heading follows each
// request. An item runs the CORDIC rotations one at a time, then four 32x18 partial
// products through one shared multiplier; the next request is accepted only once its
// result is in the output register. A finished result sits there while the next
// request is accepted; the block stalls before loading a newer result only if that
// register has not been drained. time_step resets to 1.0 and is to be written by the
// user via csr_wr_en/csr_wr_data only while idle; the block does not enforce this.
module heading_dead_reckoning_integrator #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   hdri_req_if.sink                    req_ch,
   hdri_rsp_if.source                  rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [hdri_pkg::STEP_W-1:0] csr_wr_data
);
   import hdri_pkg::*;

   hdri_cmd_type    cmd;
   hdri_status_type status;

   hdri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   hdri_datapath #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .steer_delta (req_ch.steer_delta),
      .speed       (req_ch.speed),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .new_x       (rsp_ch.new_x),
      .new_y       (rsp_ch.new_y),
      .new_heading (rsp_ch.new_heading)
   );

endmodule

@@ dv/heading_dead_reckoning_integrator_test.sv @@
`timescale 1ns / 1ps

module heading_dead_reckoning_integrator_test;

   localparam int ROT_STEPS       = 16;
   localparam int NUM_DIRECTED    = 22;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 191;
   localparam int CYCLE_LIMIT     = 800000;
   localparam int TAIL_CYCLES     = 60;
   localparam int MAX_GAP         = 14;

   localparam logic [15:0] STEP_MAX = 16'hFFFF;
   localparam logic [15:0] STEP_MIN = 16'h0000;
   localparam logic [15:0] STEP_TINY = 16'h0001;
   localparam logic [15:0] STEP_HALF_RANGE = 16'h8000;

   localparam longint POS_TOP    = 64'sd2147483647;
   localparam longint POS_BOTTOM = -64'sd2147483648;
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint ROUND_UP   = 64'sd8589934592;   // 2^33, half of the final shift
   localparam int     OUT_SHIFT  = 34;
   localparam int     ANGLE_SCALE = 16384;             // 1/128 degree to 2^-21 degree

   localparam logic signed [15:0] SPEED_TOP    = 16'sh7FFF;
   localparam logic signed [15:0] SPEED_BOTTOM = 16'sh8000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        heading;
   } pose_type;

   typedef struct packed {
      logic signed [15:0] steer;
      logic signed [15:0] speed;
      logic               typed;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        heading;
   } steer_row_type;

   // arctangent of 2^-i in 2^-21 degree units
   longint arctan_step [0:23] = '{
      94371840, 55710950, 29436136, 14942242, 7500117, 3753715,
      1877315, 938715, 469365, 234683, 117342, 58671,
      29335, 14668, 7334, 3667, 1833, 917,
      458, 229, 115, 57, 29, 14
   };

   steer_row_type steer_rows [0:NUM_DIRECTED-1] = '{
      '{16'sd0,      16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd0},
      '{16'sd11520,  16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd11520},
      '{-16'sd32768, 16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd24832},
      '{16'sd32767,  16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd11519},
      '{-16'sd11519, 16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd0},
      '{-16'sd1,     16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd46079},
      '{16'sd1,      16'sd0,      1'b1, 32'sd0, 32'sd0, 16'd0},
      '{16'sd0,      16'sd32767,  1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd0,      -16'sd32768, 1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd11520,  16'sd32767,  1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd11520,  -16'sd32768, 1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd11520,  16'sd256,    1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd11519,  16'sd256,    1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd1,      16'sd256,    1'b0, 32'sd0, 32'sd0, 16'd0},
      '{-16'sd1,     -16'sd256,   1'b0, 32'sd0, 32'sd0, 16'd0},
      '{-16'sd23040, 16'sd1,      1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd23040,  -16'sd1,     1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd5760,   16'sd12345,  1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd17280,  -16'sd200,   1'b0, 32'sd0, 32'sd0, 16'd0},
      '{-16'sd32768, 16'sd32767,  1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd32767,  -16'sd32768, 1'b0, 32'sd0, 32'sd0, 16'd0},
      '{16'sd0,      16'sd0,      1'b0, 32'sd0, 32'sd0, 16'd0}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   hdri_req_if req_if ();
   hdri_rsp_if rsp_if ();

   heading_dead_reckoning_integrator #(
      .CORDIC_ITERATIONS(ROT_STEPS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // predictor state
   longint      track_x;
   longint      track_y;
   int          track_heading;
   logic [15:0] step_cfg;

   pose_type pending_poses [$];
   int    mismatch_count;
   int    cycle_count;
   bit    gaps_on;
   int    stall_left;

   always #5 clock = ~clock;

   function automatic longint clamp_pos(input longint v);
      if (v > POS_TOP) begin
         return POS_TOP;
      end
      if (v < POS_BOTTOM) begin
         return POS_BOTTOM;
      end
      return v;
   endfunction

   // Advance the tracked pose by one transaction and return the expected response.
   function automatic pose_type advance_pose(input logic signed [15:0] st,
                                             input logic signed [15:0] sp);
      int     h;
      int     base;
      int     i;
      longint z;
      longint cx;
      longint cy;
      longint sx;
      longint sy;
      longint sin_h;
      longint cos_h;
      longint vdt;
      pose_type p;
      h = track_heading + int'(st);
      if (h < 0) begin
         h = h + int'(hdri_pkg::FULL_TURN);
      end
      if (h >= int'(hdri_pkg::FULL_TURN)) begin
         h = h - int'(hdri_pkg::FULL_TURN);
      end
      track_heading = h;

      if (h < int'(hdri_pkg::QUARTER_TURN)) begin
         base = 0;
      end else if (h < int'(hdri_pkg::HALF_TURN)) begin
         base = int'(hdri_pkg::QUARTER_TURN);
      end else if (h < int'(hdri_pkg::THREE_QUARTERS)) begin
         base = int'(hdri_pkg::HALF_TURN);
      end else begin
         base = int'(hdri_pkg::THREE_QUARTERS);
      end

      z  = longint'(h - base) * ANGLE_SCALE;
      cx = GAIN_Q30;
      cy = 0;
      for (i = 0; i < ROT_STEPS && i < 24; i++) begin
         sx = cy >>> i;
         sy = cx >>> i;
         if (z >= 0) begin
            cx = cx - sx;
            cy = cy + sy;
            z  = z - arctan_step[i];
         end else begin
            cx = cx + sx;
            cy = cy - sy;
            z  = z + arctan_step[i];
         end
      end

      // rotate the first-quadrant pair into the heading's quadrant
      if (base == 0) begin
         sin_h = cy;
         cos_h = cx;
      end else if (base == int'(hdri_pkg::QUARTER_TURN)) begin
         sin_h = cx;
         cos_h = -cy;
      end else if (base == int'(hdri_pkg::HALF_TURN)) begin
         sin_h = -cy;
         cos_h = -cx;
      end else begin
         sin_h = -cx;
         cos_h = cy;
      end

      vdt = longint'(sp) * longint'(step_cfg);
      track_x = clamp_pos(track_x + ((vdt * sin_h + ROUND_UP) >>> OUT_SHIFT));
      track_y = clamp_pos(track_y + ((vdt * cos_h + ROUND_UP) >>> OUT_SHIFT));

      p.x       = track_x[31:0];
      p.y       = track_y[31:0];
      p.heading = h[15:0];
      return p;
   endfunction

   // Caller is at a falling edge; returns at the falling edge after acceptance.
   task automatic send_req(input logic signed [15:0] st, input logic signed [15:0] sp,
                           input pose_type want);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         gap = $urandom_range(1, MAX_GAP);
         repeat (gap) @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.steer_delta = st;
      req_if.speed       = sp;
      do @(posedge clock); while (!req_if.ready);
      pending_poses.push_back(want);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (pending_poses.size() != 0) @(negedge clock);
   endtask

   task automatic write_step(input logic [15:0] val);
      csr_wr_en   = 1'b1;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      step_cfg  = val;
   endtask

   // response ready with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left   = stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         rsp_if.ready = 1'b0;
         stall_left   = $urandom_range(1, MAX_GAP) - 1;
      end else begin
         rsp_if.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: response with nothing pending: x %0d y %0d heading %0d",
                     $time, rsp_if.new_x, rsp_if.new_y, rsp_if.new_heading);
            mismatch_count = mismatch_count + 1;
         end else begin
            if (rsp_if.new_x !== pending_poses[0].x) begin
               $display("%0t: new_x expected %0d got %0d", $time,
                        pending_poses[0].x, rsp_if.new_x);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_if.new_y !== pending_poses[0].y) begin
               $display("%0t: new_y expected %0d got %0d", $time,
                        pending_poses[0].y, rsp_if.new_y);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_if.new_heading !== pending_poses[0].heading) begin
               $display("%0t: new_heading expected %0d got %0d", $time,
                        pending_poses[0].heading, rsp_if.new_heading);
               mismatch_count = mismatch_count + 1;
            end
            void'(pending_poses.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("heading_dead_reckoning_integrator test failed");
         $finish;
      end
   end

   initial begin
      int                 k;
      int                 ph;
      int                 run_left;
      logic signed [15:0] run_speed;
      logic signed [15:0] st;
      logic signed [15:0] sp;
      logic [15:0]        ts;
      pose_type           want;

      clock              = 1'b0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.steer_delta = '0;
      req_if.speed       = '0;
      rsp_if.ready       = 1'b0;
      track_x            = 0;
      track_y            = 0;
      track_heading      = 0;
      step_cfg           = hdri_pkg::TIME_STEP_RESET;
      mismatch_count     = 0;
      cycle_count        = 0;
      stall_left         = 0;
      gaps_on            = 1'b1;
      run_left           = 0;
      run_speed          = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < NUM_DIRECTED; k++) begin
         want = advance_pose(steer_rows[k].steer, steer_rows[k].speed);
         if (steer_rows[k].typed) begin
            want.x       = steer_rows[k].x;
            want.y       = steer_rows[k].y;
            want.heading = steer_rows[k].heading;
         end
         send_req(steer_rows[k].steer, steer_rows[k].speed, want);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         case (ph)
            0:       ts = STEP_MAX;
            1:       ts = STEP_MIN;
            2:       ts = STEP_TINY;
            3:       ts = STEP_HALF_RANGE;
            4:       ts = hdri_pkg::TIME_STEP_RESET;
            default: ts = 16'($urandom_range(0, 65535));
         endcase
         write_step(ts);
         gaps_on = (ph != NUM_PHASES - 1);

         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // hold off until the block has answered everything
            if (k == ITEMS_PER_PHASE / 2) begin
               wait_drained();
            end
            // straight runs at full speed push the position into saturation
            if (run_left == 0 && $urandom_range(0, 29) == 0) begin
               run_left  = $urandom_range(20, 48);
               run_speed = ($urandom_range(0, 1) != 0) ? SPEED_TOP : SPEED_BOTTOM;
            end
            if (run_left > 0) begin
               run_left = run_left - 1;
               st = 16'(int'($urandom_range(0, 8)) - 4);
               sp = run_speed;
            end else begin
               case ($urandom_range(0, 9))
                  0:       st = 16'($urandom_range(0, 65535));
                  1:       st = 16'(int'($urandom_range(0, 64)) - 32);
                  default: st = 16'(int'($urandom_range(0, 46080)) - 23040);
               endcase
               if ($urandom_range(0, 3) == 0) begin
                  sp = 16'(int'($urandom_range(0, 512)) - 256);
               end else begin
                  sp = 16'($urandom_range(0, 65535));
               end
            end
            want = advance_pose(st, sp);
            send_req(st, sp, want);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("heading_dead_reckoning_integrator test passed");
      end else begin
         $display("heading_dead_reckoning_integrator test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/hdri_pkg.sv
hw/rtl/hdri_if.sv
hw/rtl/hdri_ctrl.sv
hw/rtl/hdri_datapath.sv
hw/rtl/heading_dead_reckoning_integrator.sv
dv/heading_dead_reckoning_integrator_test.sv
